/* design/cid_pkg.sv */
// Package for the CAN identifier anomaly detector.
// Holds sizes, command and status codes, item types and controller handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cid_pkg;

	localparam int TABLE_ENTRIES     = 32;
	localparam int MAX_PAYLOAD_BYTES = 64;
	localparam int WORDS_PER_ENTRY   = (MAX_PAYLOAD_BYTES + 7) / 8;
	localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RAM_DEPTH = TABLE_ENTRIES * WORDS_PER_ENTRY;
	localparam int ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	localparam logic [9:0] THRESHOLD_RESET = 10'd8;
	localparam logic [9:0] DIST_MAX        = 10'd1023;

	typedef enum logic [1:0] {
		KIND_EVAL      = 2'd0,
		KIND_LEARN     = 2'd1,
		KIND_LEARN_PAT = 2'd2,
		KIND_CLEAR     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_NEW_ID = 2'd1,
		ST_OVER   = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [28:0] can_id;
		logic [6:0]  byte_length;
		logic        is_error_frame;
		logic        is_remote;
		logic [63:0] time_stamp;
		logic [2:0]  word_index;
		logic [63:0] data_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [28:0] result_id;
		logic [9:0]  bit_distance;
		logic        id_known;
		logic [63:0] result_time;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic read;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} ctrl_stat_t;

endpackage
`default_nettype wire

/* design/cid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cid_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* design/cid_ctrl.sv */
// Controller: sequences each item through capture, lookup, pattern read and execute.
// Depends on cid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cid_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  cid_pkg::ctrl_stat_t     stat,
	output cid_pkg::ctrl_cmd_t      cmd
);
	import cid_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_READ = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				// hold while the output register is full and stalled
				if (!stat.out_blocked) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

/* design/cid_dp.sv */
// Datapath: identifier table, lookup, pattern memory, distance count, output register.
// Depends on cid_pkg and cid_ram.
`timescale 1ns / 1ps
`default_nettype none
module cid_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cid_pkg::in_item_t       in_item,
	input  cid_pkg::ctrl_cmd_t      cmd,
	output cid_pkg::ctrl_stat_t     stat,
	input  wire logic               cfg_valid,
	input  wire logic [9:0]         cfg_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cid_pkg::out_item_t      out_item
);
	import cid_pkg::*;

	in_item_t         item_q;
	logic [9:0]       thr_q;
	logic             valid_q   [TABLE_ENTRIES];
	logic             haspat_q  [TABLE_ENTRIES];
	logic [28:0]      id_q      [TABLE_ENTRIES];
	logic [6:0]       plen_q    [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] matched_q;
	logic [2:0]       flags_q;   // [0] known, [1] has pattern, [2] slot available
	logic [9:0]       dist_q;
	logic             out_valid_q;
	out_item_t        out_q;

	// lookup: first hit wins, otherwise first free slot
	logic               hit, have_free;
	logic [ENTRY_W-1:0] hit_idx, free_idx;
	always_comb begin
		hit = 1'b0; have_free = 1'b0; hit_idx = '0; free_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!hit && valid_q[i] && id_q[i] == item_q.can_id) begin
				hit = 1'b1;
				hit_idx = ENTRY_W'(i);
			end
			if (!have_free && !valid_q[i]) begin
				have_free = 1'b1;
				free_idx = ENTRY_W'(i);
			end
		end
	end

	// pattern memory
	logic             widx_ok;
	logic [ADDR_W-1:0] addr;
	logic [63:0]      pat_word;
	logic             ram_we;
	logic [1:0]       kind;
	logic             skip, eval_cmp;

	assign widx_ok = ({1'b0, item_q.word_index} < 4'(WORDS_PER_ENTRY));
	assign addr = ADDR_W'(matched_q) * ADDR_W'(WORDS_PER_ENTRY) + ADDR_W'(item_q.word_index);
	assign kind = item_q.kind;
	assign skip = item_q.is_error_frame | item_q.is_remote;
	assign eval_cmp = (kind == KIND_EVAL) && !skip && flags_q[0] && flags_q[1] && widx_ok;
	assign ram_we = cmd.exec && (kind == KIND_LEARN_PAT) && flags_q[2] && widx_ok;

	cid_ram #(.WIDTH(64), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (item_q.data_word),
		.re    (cmd.read),
		.raddr (addr),
		.rdata (pat_word)
	);

	// distance over the shorter length
	logic [6:0]  len_sat, plen, cmp_len;
	logic [63:0] mask, diff;
	logic [6:0]  pop;
	logic [10:0] sum;
	logic [9:0]  new_dist;
	always_comb begin
		len_sat = (item_q.byte_length > 7'(MAX_PAYLOAD_BYTES)) ?
			7'(MAX_PAYLOAD_BYTES) : item_q.byte_length;
		plen    = plen_q[matched_q];
		cmp_len = (plen < len_sat) ? plen : len_sat;
		for (int b = 0; b < 8; b++) begin
			mask[b*8 +: 8] = ({1'b0, item_q.word_index, 3'(b)} < cmp_len) ? 8'hFF : 8'h00;
		end
		diff = (pat_word ^ item_q.data_word) & mask;
		pop  = 7'($countones(diff));
		sum  = {1'b0, dist_q} + 11'(pop);
		new_dist = eval_cmp ? ((sum > 11'(DIST_MAX)) ? DIST_MAX : sum[9:0]) : dist_q;
	end

	// result build
	logic      has_res;
	out_item_t res;
	always_comb begin
		has_res = 1'b0;
		res.status       = ST_NONE;
		res.result_id    = item_q.can_id;
		res.bit_distance = '0;
		res.id_known     = flags_q[0];
		res.result_time  = item_q.time_stamp;
		if (item_q.last_word) begin
			if (kind == KIND_EVAL && !skip) begin
				has_res = 1'b1;
				if (!flags_q[0]) begin
					res.status = ST_NEW_ID;
				end else if (flags_q[1]) begin
					res.bit_distance = new_dist;
					if (new_dist > thr_q) res.status = ST_OVER;
				end
			end else if ((kind == KIND_LEARN || kind == KIND_LEARN_PAT) && !flags_q[2]) begin
				has_res = 1'b1;
				res.status = ST_FULL;
				res.id_known = 1'b0;
			end
		end
	end

	assign stat.out_blocked = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.exec && item_q.last_word && flags_q[2] &&
				(kind == KIND_LEARN || kind == KIND_LEARN_PAT)) begin
			id_q[matched_q] <= item_q.can_id;
			if (kind == KIND_LEARN_PAT) plen_q[matched_q] <= len_sat;
		end
		if (cmd.exec && has_res) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESHOLD_RESET;
			matched_q   <= '0;
			flags_q     <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				valid_q[i]  <= 1'b0;
				haspat_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_valid) thr_q <= cfg_data;
			if (cmd.lookup && item_q.word_index == 3'd0) begin
				dist_q <= '0;
				if (hit) begin
					matched_q <= hit_idx;
					flags_q   <= {1'b1, haspat_q[hit_idx], 1'b1};
				end else begin
					matched_q <= have_free ? free_idx : '0;
					flags_q   <= {have_free, 2'b00};
				end
			end
			if (cmd.exec) begin
				dist_q <= new_dist;
				if (item_q.last_word) begin
					if (kind == KIND_CLEAR) begin
						for (int i = 0; i < TABLE_ENTRIES; i++) begin
							valid_q[i]  <= 1'b0;
							haspat_q[i] <= 1'b0;
						end
					end else if (kind != KIND_EVAL && flags_q[2]) begin
						valid_q[matched_q] <= 1'b1;
						if (kind == KIND_LEARN_PAT) haspat_q[matched_q] <= 1'b1;
						else if (!flags_q[0]) haspat_q[matched_q] <= 1'b0;
					end
				end
			end
			if (cmd.exec && has_res) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule
`default_nettype wire

/* design/can_id_anomaly_detector_top.sv */
// Top level of the CAN identifier anomaly detector.
// Depends on cid_pkg, cid_ctrl, cid_dp (which holds cid_ram).
//
//  channel | signals                       | direction | accepted when
//  --------+-------------------------------+-----------+------------------------
//  in      | in_valid, in_stall, in_item   | into      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_item| out of    | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data| into      | cfg_valid && cfg_ready
//
// Each item passes through four steps: capture, table lookup, pattern RAM read, execute.
// The read of the pattern RAM is registered, so it has its own step; one item is in flight.
// Execute waits while the output register holds an untaken result, so with a
// stalled output the next item is still captured but not finished.
// Reset clears the table valid and pattern flags at once; no clearing pass.
// The threshold register resets to 8; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module can_id_anomaly_detector_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  cid_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output cid_pkg::out_item_t    out_item,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [9:0]       cfg_data
);
	import cid_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	// sequencer
	cid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, pattern memory and result register
	cid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// one item at a time: an accepted item blocks the input on the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is in flight");

	// a result only appears while an item is being worked on
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in flight");
endmodule
`default_nettype wire
